// ===== rtl/feistel_block_cipher_64_defines.svh =====
// Assertion macros shared by the cipher RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef FEISTEL_BLOCK_CIPHER_64_DEFINES_SVH
`define FEISTEL_BLOCK_CIPHER_64_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBC64_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FBC64_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fbc64_pkg.sv =====
// Types, constants and key-schedule helpers of the 64-bit Feistel cipher.
// Depends on nothing; used by every other file of the block but the assertion header.
`timescale 1ns / 1ps
`default_nettype none

package fbc64_pkg;

  // Block and half-block geometry.
  localparam int unsigned BLOCK_W = 64;
  localparam int unsigned HALF_W  = 32;

  // Number of Feistel rounds; each round is two pipeline stages.
  localparam int unsigned ROUNDS = 16;

  // Key storage: sixteen bytes, indexed by a four-bit counter.
  localparam int unsigned KEY_BYTES = 16;
  localparam int unsigned KEY_IDX_W = 4;
  localparam logic [KEY_IDX_W-1:0] KEY_LAST = KEY_IDX_W'(KEY_BYTES - 1);

  // Generator and round-function constants.
  localparam logic [HALF_W-1:0] GEN_XOR = 32'hA3B1C6D9;
  localparam logic [HALF_W-1:0] GEN_MUL = 32'h41C64E6D;
  localparam logic [HALF_W-1:0] GEN_ADD = 32'h00003039;
  localparam logic [HALF_W-1:0] MIX_MUL = 32'h9E3779B9;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SEED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 2'd1;

  // Queue between the front and the back.
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_CNT_W = 2;
  localparam logic [FIFO_CNT_W-1:0] FIFO_FULL = FIFO_CNT_W'(FIFO_DEPTH);

  typedef logic [KEY_BYTES-1:0][7:0] key_t;

  // One block in flight. For decryption the halves travel swapped so that
  // the same round datapath serves both directions.
  typedef struct packed {
    logic              dec;
    logic [HALF_W-1:0] left;
    logic [HALF_W-1:0] right;
  } item_t;

  // Key byte feeding byte position pos (0 is the most significant) of the
  // subkey of round rnd.
  function automatic logic [KEY_IDX_W-1:0] key_byte_idx(input int unsigned rnd,
                                                         input int unsigned pos);
    int unsigned v;
    v = rnd * (2 * pos + 1) + pos;
    return v[KEY_IDX_W-1:0];
  endfunction

  // Subkey of round rnd gathered from four key bytes.
  function automatic logic [HALF_W-1:0] subkey(input key_t k, input int unsigned rnd);
    logic [HALF_W-1:0] sk;
    sk = '0;
    for (int unsigned pos = 0; pos < 4; pos++) begin
      sk[HALF_W-1-8*pos -: 8] = k[key_byte_idx(rnd, pos)];
    end
    return sk;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fbc64_in_if.sv =====
// Input channel of the cipher: valid/ready handshake carrying one block.
// Depends on fbc64_pkg for the block width.
`timescale 1ns / 1ps
`default_nettype none

interface fbc64_in_if;
  logic                         valid;
  logic                         ready;
  logic [fbc64_pkg::BLOCK_W-1:0] block_in;

  modport source (output valid, output block_in, input ready);
  modport sink   (input valid, input block_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/fbc64_out_if.sv =====
// Output channel of the cipher: valid/ready handshake carrying one block.
// Depends on fbc64_pkg for the block width.
`timescale 1ns / 1ps
`default_nettype none

interface fbc64_out_if;
  logic                         valid;
  logic                         ready;
  logic [fbc64_pkg::BLOCK_W-1:0] block_out;

  modport source (output valid, output block_out, input ready);
  modport sink   (input valid, input block_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/fbc64_keygen.sv =====
// Key schedule sequencer: steps the linear congruential generator once per
// cycle and fills the sixteen key bytes. Depends on fbc64_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "feistel_block_cipher_64_defines.svh"

module fbc64_keygen (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              seed_we_i,
  input  wire logic [fbc64_pkg::HALF_W-1:0] seed_i,
  output logic                   busy_o,
  output fbc64_pkg::key_t        key_o
);

  logic [fbc64_pkg::HALF_W-1:0]    word_q, word_d;
  logic [fbc64_pkg::KEY_IDX_W-1:0] cnt_q, cnt_d;
  logic                            busy_q, busy_d;
  logic [fbc64_pkg::HALF_W-1:0]    lcg_next;
  fbc64_pkg::key_t                 key_q;

  // One generator step: multiply and add, modulo 2^32.
  assign lcg_next = word_q * fbc64_pkg::GEN_MUL + fbc64_pkg::GEN_ADD;

  // A seed write restarts the sequence; otherwise step while busy.
  always_comb begin
    word_d = word_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (seed_we_i) begin
      word_d = seed_i ^ fbc64_pkg::GEN_XOR;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      word_d = lcg_next;
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == fbc64_pkg::KEY_LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  // Reset starts the schedule from the zero seed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= fbc64_pkg::GEN_XOR;
      cnt_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      word_q <= word_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  // Key byte i takes bits 23..16 of generator output i+1.
  always_ff @(posedge clk_i) begin
    if (busy_q && !seed_we_i) begin
      key_q[cnt_q] <= lcg_next[23:16];
    end
  end

  assign busy_o = busy_q;
  assign key_o  = key_q;

  `FBC64_ASSERT_NXT(a_seed_restarts, clk_i, rst_ni, seed_we_i, busy_q && (cnt_q == '0), "seed write did not restart the key schedule")
  `FBC64_ASSERT_NXT(a_sched_ends, clk_i, rst_ni, busy_q && (cnt_q == fbc64_pkg::KEY_LAST) && !seed_we_i, !busy_q, "key schedule ran past the last byte")

endmodule

`default_nettype wire

// ===== rtl/fbc64_round.sv =====
// One Feistel round as two pipeline stages: mix and multiply, then fold
// and swap. Depends on fbc64_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbc64_round (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire fbc64_pkg::item_t             item_i,
  input  wire logic [fbc64_pkg::HALF_W-1:0] enc_key_i,
  input  wire logic [fbc64_pkg::HALF_W-1:0] dec_key_i,
  output logic                              valid_o,
  output fbc64_pkg::item_t                  item_o
);

  logic [fbc64_pkg::HALF_W-1:0] key;
  logic [fbc64_pkg::HALF_W-1:0] pre;
  logic [fbc64_pkg::HALF_W-1:0] p_q;
  logic [fbc64_pkg::HALF_W-1:0] folded;
  logic                         va_q, vb_q;
  fbc64_pkg::item_t             ia_q, ib_q;

  // Decryption runs the rounds in reverse key order.
  always_comb begin
    key = item_i.dec ? dec_key_i : enc_key_i;
    pre = {item_i.right[4:0], item_i.right[fbc64_pkg::HALF_W-1:5]} ^ key;
  end

  // The product is folded onto itself in the second stage.
  assign folded = p_q ^ (p_q >> 16);

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  // Payload of both stages; the halves swap at the end of the round.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ia_q       <= item_i;
      p_q        <= pre * fbc64_pkg::MIX_MUL;
      ib_q.dec   <= ia_q.dec;
      ib_q.left  <= ia_q.right;
      ib_q.right <= ia_q.left ^ folded;
    end
  end

  assign valid_o = vb_q;
  assign item_o  = ib_q;

endmodule

`default_nettype wire

// ===== rtl/fbc64_front.sv =====
// Front end: accepts blocks, tags them with the direction, orders the
// halves and queues them for the round pipeline. Depends on fbc64_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "feistel_block_cipher_64_defines.svh"

module fbc64_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  fbc64_in_if.sink          in_ch,
  input  wire logic         kg_busy_i,
  input  wire logic         decrypt_i,
  output fbc64_pkg::item_t  head_o,
  output logic              head_valid_o,
  input  wire logic         head_pop_i
);

  fbc64_pkg::item_t                 fifo_q [fbc64_pkg::FIFO_DEPTH];
  logic [fbc64_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [fbc64_pkg::FIFO_CNT_W-1:0] cnt_q;
  logic                             push;
  fbc64_pkg::item_t                 item;

  // No block is taken while the key bytes are being derived.
  assign in_ch.ready = (cnt_q != fbc64_pkg::FIFO_FULL) && !kg_busy_i;
  assign push        = in_ch.valid && in_ch.ready;

  // Decryption enters with its halves swapped.
  always_comb begin
    item.dec = decrypt_i;
    if (decrypt_i) begin
      item.left  = in_ch.block_in[fbc64_pkg::HALF_W-1:0];
      item.right = in_ch.block_in[fbc64_pkg::BLOCK_W-1:fbc64_pkg::HALF_W];
    end else begin
      item.left  = in_ch.block_in[fbc64_pkg::BLOCK_W-1:fbc64_pkg::HALF_W];
      item.right = in_ch.block_in[fbc64_pkg::HALF_W-1:0];
    end
  end

  // Queue pointers and fill count; pointers wrap at the power-of-two depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (head_pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !head_pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push && head_pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

  assign head_o       = fifo_q[rd_ptr_q];
  assign head_valid_o = (cnt_q != '0);

  `FBC64_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, head_pop_i, cnt_q != '0, "queue popped while empty")

endmodule

`default_nettype wire

// ===== rtl/fbc64_back.sv =====
// Back end: the round pipeline and the output register. Depends on
// fbc64_pkg and fbc64_round.
`timescale 1ns / 1ps
`default_nettype none
`include "feistel_block_cipher_64_defines.svh"

module fbc64_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fbc64_pkg::key_t   key_i,
  input  wire fbc64_pkg::item_t  head_i,
  input  wire logic              head_valid_i,
  output logic                   head_pop_o,
  fbc64_out_if.source            out_ch
);

  logic                     en;
  logic [fbc64_pkg::ROUNDS:0] vld;
  fbc64_pkg::item_t         itm [fbc64_pkg::ROUNDS+1];
  fbc64_pkg::item_t         last;
  logic                     out_valid_q;
  logic [fbc64_pkg::BLOCK_W-1:0] out_block_q;

  // The whole pipeline advances unless a finished block is held up.
  assign en         = !out_valid_q || out_ch.ready;
  assign head_pop_o = en && head_valid_i;

  assign vld[0] = head_valid_i;
  assign itm[0] = head_i;

  // One round per instance, each with its encryption and decryption subkey.
  for (genvar r = 0; r < fbc64_pkg::ROUNDS; r++) begin : g_round
    fbc64_round u_round (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (vld[r]),
      .item_i    (itm[r]),
      .enc_key_i (fbc64_pkg::subkey(key_i, r)),
      .dec_key_i (fbc64_pkg::subkey(key_i, fbc64_pkg::ROUNDS - 1 - r)),
      .valid_o   (vld[r+1]),
      .item_o    (itm[r+1])
    );
  end

  assign last = itm[fbc64_pkg::ROUNDS];

  // Output register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld[fbc64_pkg::ROUNDS];
    end
  end

  // Decrypted blocks swap their halves back on the way out.
  always_ff @(posedge clk_i) begin
    if (en && vld[fbc64_pkg::ROUNDS]) begin
      out_block_q <= last.dec ? {last.right, last.left} : {last.left, last.right};
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.block_out = out_block_q;

  `FBC64_ASSERT_NXT(a_stall_holds, clk_i, rst_ni, !en, $stable(vld[fbc64_pkg::ROUNDS:1]), "round pipeline moved while stalled")

endmodule

`default_nettype wire

// ===== rtl/feistel_block_cipher_64.sv =====
// Top level of the 64-bit Feistel block cipher engine.
// Depends on fbc64_pkg, the channel interfaces, fbc64_keygen, fbc64_front
// and fbc64_back.
`timescale 1ns / 1ps
`default_nettype none

// The engine takes one 64-bit block per cycle while input ready is high and
// returns it enciphered or deciphered, in order. A block is written into the
// input queue at the edge that accepts it, passes two stages per round (the
// 32x32 multiply of the round function is registered before its fold) and is
// then loaded into the output register. While a result waits on the output the
// whole round pipeline holds and the two-entry input queue takes the blocks
// that arrive meanwhile. The user must write key_seed and decrypt_mode only
// while no block is in flight; the engine itself does not enforce this. After
// reset and after every key_seed write the key schedule runs on its single
// generator multiplier, one key byte per cycle, and input ready stays low
// until it finishes; decrypt_mode writes take effect at once.
module feistel_block_cipher_64 (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  fbc64_in_if.sink                              in_ch,
  fbc64_out_if.source                           out_ch,
  input  wire logic                             cfg_we_i,
  input  wire logic [fbc64_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [fbc64_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  logic             decrypt_q;
  logic             seed_we;
  logic             kg_busy;
  fbc64_pkg::key_t  key;
  fbc64_pkg::item_t head;
  logic             head_valid;
  logic             head_pop;

  // Register decode; writes to unknown indexes are dropped.
  assign seed_we = cfg_we_i && (cfg_idx_i == fbc64_pkg::REG_KEY_SEED);

  // Direction register keeps bit 0 of the written value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q <= 1'b0;
    end else if (cfg_we_i && (cfg_idx_i == fbc64_pkg::REG_DECRYPT_MODE)) begin
      decrypt_q <= cfg_wdata_i[0];
    end
  end

  fbc64_keygen u_keygen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seed_we_i (seed_we),
    .seed_i    (cfg_wdata_i[fbc64_pkg::HALF_W-1:0]),
    .busy_o    (kg_busy),
    .key_o     (key)
  );

  fbc64_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .kg_busy_i    (kg_busy),
    .decrypt_i    (decrypt_q),
    .head_o       (head),
    .head_valid_o (head_valid),
    .head_pop_i   (head_pop)
  );

  fbc64_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_i        (key),
    .head_i       (head),
    .head_valid_i (head_valid),
    .head_pop_o   (head_pop),
    .out_ch       (out_ch)
  );

endmodule

`default_nettype wire
